// ----- src/gbn_pkg.sv -----
`default_nettype none
package gbn_pkg;

  // Sequence space; the 3-bit sequence fields fix it at eight numbers
  localparam int SEQ_COUNT = 8;
  localparam int SEQ_W     = 3;

  // Command queue between the front and back parts
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input item codes
  localparam logic [1:0] MODE_DATA    = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_ACK_OK   = 3'd2,
    KIND_ACK_IGN  = 3'd3,
    KIND_IDLE_TMO = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       payload_byte;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] frame_seq;
    logic [7:0]       frame_byte;
    logic [SEQ_W-1:0] freed_count;
    logic [SEQ_W-1:0] outstanding;
    logic             window_is_empty;
    logic             last;
  } out_item_t;

  // One classified item: a finished result, a store write plus result,
  // or a replay of count frames starting at seq_start
  typedef struct packed {
    logic             replay;
    logic             wr;
    logic [SEQ_W-1:0] seq_start;
    logic [SEQ_W-1:0] count;
    out_item_t        res;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_REPLAY
  } bk_state_t;

endpackage
`default_nettype wire

// ----- src/gbn_front.sv -----
`default_nettype none
module gbn_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               accept,
  input  gbn_pkg::in_item_t in_item,
  output logic              push,
  output gbn_pkg::cmd_t     cmd
);
  import gbn_pkg::*;

  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0] last_acked_r, last_acked_nxt;
  logic [SEQ_W-1:0] outst_r, outst_nxt;
  logic [SEQ_W:0]   gap;
  logic [SEQ_W-1:0] freed;

  // Distance from the last ack to the new one, modulo the sequence space
  always_comb begin
    gap = {1'b0, in_item.ack_seq} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, last_acked_r};
    if (gap >= (SEQ_W+1)'(SEQ_COUNT)) begin
      gap = gap - (SEQ_W+1)'(SEQ_COUNT);
    end
    freed = gap[SEQ_W-1:0];
  end

  // Classify the item, build its command and update the window
  always_comb begin
    next_seq_nxt   = next_seq_r;
    last_acked_nxt = last_acked_r;
    outst_nxt      = outst_r;
    push           = 1'b0;
    cmd            = '0;
    cmd.res.kind   = KIND_SENT;
    cmd.res.last   = 1'b1;
    cmd.res.outstanding = outst_r;
    case (in_item.mode)
      MODE_DATA: begin
        push = accept;
        if (outst_r >= SEQ_W'(SEQ_COUNT - 1)) begin
          cmd.res.kind = KIND_FULL;
        end else begin
          cmd.wr              = 1'b1;
          cmd.res.frame_seq   = next_seq_r;
          cmd.res.frame_byte  = in_item.payload_byte;
          cmd.res.outstanding = outst_r + 1'b1;
          if (accept) begin
            outst_nxt    = outst_r + 1'b1;
            next_seq_nxt = (next_seq_r == SEQ_W'(SEQ_COUNT - 1)) ? '0 : next_seq_r + 1'b1;
          end
        end
      end
      MODE_ACK: begin
        push = accept;
        if (int'(in_item.ack_seq) >= SEQ_COUNT || freed > outst_r) begin
          cmd.res.kind = KIND_ACK_IGN;
        end else begin
          cmd.res.kind        = KIND_ACK_OK;
          cmd.res.freed_count = freed;
          cmd.res.outstanding = outst_r - freed;
          if (accept) begin
            outst_nxt      = outst_r - freed;
            last_acked_nxt = in_item.ack_seq;
          end
        end
      end
      MODE_TIMEOUT: begin
        push = accept;
        if (outst_r == '0) begin
          cmd.res.kind = KIND_IDLE_TMO;
        end else begin
          cmd.replay    = 1'b1;
          cmd.count     = outst_r;
          cmd.seq_start = (last_acked_r == SEQ_W'(SEQ_COUNT - 1)) ? '0 : last_acked_r + 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    cmd.res.window_is_empty = (cmd.res.outstanding == '0);
  end

  // Hold window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r   <= '0;
      last_acked_r <= SEQ_W'(SEQ_COUNT - 1);
      outst_r      <= '0;
    end else begin
      next_seq_r   <= next_seq_nxt;
      last_acked_r <= last_acked_nxt;
      outst_r      <= outst_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/gbn_queue.sv -----
`default_nettype none
module gbn_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  gbn_pkg::cmd_t  push_cmd,
  input  wire            pop,
  output gbn_pkg::cmd_t  head,
  output logic           empty,
  output logic           full
);
  import gbn_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/gbn_back.sv -----
`default_nettype none
module gbn_back (
  input  wire                clk,
  input  wire                rst_n,
  input  gbn_pkg::cmd_t      head,
  input  wire                empty,
  output logic               pop,
  output logic               out_valid,
  output gbn_pkg::out_item_t out_item
);
  import gbn_pkg::*;

  logic [7:0]       store_r [SEQ_COUNT];
  logic             store_we;
  logic [7:0]       rd_byte_r;

  bk_state_t        state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [SEQ_W-1:0] cnt_r, cnt_nxt;
  logic [SEQ_W-1:0] outst_r, outst_nxt;
  logic             valid_r, valid_nxt;
  out_item_t        item_r, item_nxt;

  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Take commands, replay the window one frame per cycle
  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    outst_nxt = outst_r;
    valid_nxt = 1'b0;
    item_nxt  = item_r;
    pop       = 1'b0;
    store_we  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.replay) begin
            seq_nxt   = head.seq_start;
            cnt_nxt   = head.count;
            outst_nxt = head.res.outstanding;
            state_nxt = BK_REPLAY;
          end else begin
            store_we  = head.wr;
            valid_nxt = 1'b1;
            item_nxt  = head.res;
          end
        end
      end
      BK_REPLAY: begin
        valid_nxt                = 1'b1;
        item_nxt                 = '0;
        item_nxt.kind            = KIND_SENT;
        item_nxt.frame_seq       = seq_r;
        item_nxt.frame_byte      = rd_byte_r;
        item_nxt.outstanding     = outst_r;
        item_nxt.window_is_empty = 1'b0;
        item_nxt.last            = (cnt_r == SEQ_W'(1));
        seq_nxt = (seq_r == SEQ_W'(SEQ_COUNT - 1)) ? '0 : seq_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == SEQ_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seq_r   <= seq_nxt;
    cnt_r   <= cnt_nxt;
    outst_r <= outst_nxt;
    item_r  <= item_nxt;
  end

  // Write sent frames into the store; prefetch the byte of the next replay slot
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[head.res.frame_seq] <= head.res.frame_byte;
    end
    rd_byte_r <= store_r[seq_nxt];
  end

endmodule
`default_nettype wire

// ----- src/go_back_n_send_window.sv -----
// Go-Back-N send window.
// Input channel: drive in_item and raise start; the item is taken at a rising
// edge where start is high and busy is low. Items are a new payload byte, a
// cumulative ack, or a retransmit timeout; mode 3 is taken and gives nothing.
// Result channel: out_valid marks each result on out_item for one cycle; the
// receiver cannot hold results off, so there is no stall path on this side.
// With the command queue empty, the single result of a byte, an ack or an idle
// timeout goes through the queue and then the back part's output register.
// A timeout with n frames outstanding first loads the replay state and
// then shows the n resent frames one per cycle, the last one marked.
// Throughput: bytes and acks go at one per cycle while busy is low. The
// front updates the window at once and pushes into a four-entry command
// queue; busy rises when it is full, which only a timeout replay can cause.
// Reset (rst_n low, synchronous) empties the window and queue and clears
// out_valid; the frame store holds no reset value and is read only at
// outstanding entries.
`default_nettype none
module go_back_n_send_window (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  gbn_pkg::in_item_t  in_item,
  output logic               out_valid,
  output gbn_pkg::out_item_t out_item
);
  import gbn_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  cmd_t push_cmd;
  cmd_t head;

  assign busy   = q_full;
  assign accept = start && !busy;

  gbn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .push    (push),
    .cmd     (push_cmd)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- src/gbn_checker.sv -----
`default_nettype none
module gbn_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input gbn_pkg::out_item_t out_item
);
  import gbn_pkg::*;

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // Empty flag agrees with the outstanding count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.window_is_empty == (out_item.outstanding == '0)))
    else $error("window_is_empty disagrees with outstanding");

  // Every result that is not a sent frame ends its item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind != KIND_SENT) |-> out_item.last)
    else $error("non-frame result not marked last");

  // Refusal only with a full window
  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == KIND_FULL) |->
      (out_item.outstanding == SEQ_W'(SEQ_COUNT - 1)))
    else $error("byte refused while window not full");

  // Results without a frame carry zero payload fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind == KIND_FULL || out_item.kind == KIND_ACK_IGN ||
                   out_item.kind == KIND_IDLE_TMO)) |->
      (out_item.frame_seq == '0 && out_item.frame_byte == '0 &&
       out_item.freed_count == '0))
    else $error("frame fields set on a result without a frame");

endmodule

bind go_back_n_send_window gbn_checker u_gbn_checker (.*);
`default_nettype wire

// ----- tb/tb_go_back_n_send_window.sv -----
`default_nettype none
module tb_go_back_n_send_window;
  import gbn_pkg::*;

  // Mode 3 is accepted and produces nothing
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 58;

  // Window predictor plus queue of frames and reports still to come out
  class window_scoreboard;
    logic [7:0] frame_bytes [SEQ_COUNT];
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] base_acked;
    logic [SEQ_W-1:0] in_flight;
    out_item_t expected_q [$];
    int fail_count;
    int checked_count;
    int data_count;
    int ack_count;
    int timeout_count;
    int resent_count;

    function new();
      next_seq      = '0;
      base_acked    = SEQ_W'(SEQ_COUNT - 1);
      in_flight     = '0;
      fail_count    = 0;
      checked_count = 0;
      data_count    = 0;
      ack_count     = 0;
      timeout_count = 0;
      resent_count  = 0;
    endfunction

    // Queue one result, taking occupancy from the window after the update
    function void push_result(kind_t k, logic [SEQ_W-1:0] sn, logic [7:0] data,
                              logic [SEQ_W-1:0] freed, logic is_last);
      out_item_t r;
      r.kind            = k;
      r.frame_seq       = sn;
      r.frame_byte      = data;
      r.freed_count     = freed;
      r.outstanding     = in_flight;
      r.window_is_empty = (in_flight == 0);
      r.last            = is_last;
      expected_q.push_back(r);
    endfunction

    // Advance the window for one accepted item and queue what it causes
    function void note_item(in_item_t it);
      logic [SEQ_W-1:0] freed;
      logic [SEQ_W-1:0] sn;
      case (it.mode)
        MODE_DATA: begin
          data_count++;
          if (in_flight == SEQ_W'(SEQ_COUNT - 1)) begin
            push_result(KIND_FULL, '0, '0, '0, 1'b1);
          end else begin
            sn = next_seq;
            frame_bytes[sn] = it.payload_byte;
            next_seq++;
            in_flight++;
            push_result(KIND_SENT, sn, it.payload_byte, '0, 1'b1);
          end
        end
        MODE_ACK: begin
          ack_count++;
          // Distance from the last ack wraps in the 3-bit sequence space
          freed = it.ack_seq - base_acked;
          if (freed > in_flight) begin
            push_result(KIND_ACK_IGN, '0, '0, '0, 1'b1);
          end else begin
            in_flight  = in_flight - freed;
            base_acked = it.ack_seq;
            push_result(KIND_ACK_OK, '0, '0, freed, 1'b1);
          end
        end
        MODE_TIMEOUT: begin
          timeout_count++;
          if (in_flight == 0) begin
            push_result(KIND_IDLE_TMO, '0, '0, '0, 1'b1);
          end else begin
            // Resend oldest first; mark the newest
            for (int i = 1; i <= in_flight; i++) begin
              sn = base_acked + SEQ_W'(i);
              resent_count++;
              push_result(KIND_SENT, sn, frame_bytes[sn], '0, i == in_flight);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        fail_count++;
      end
    endfunction

    // Match one result against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d seq %0d", got.kind, got.frame_seq);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      checked_count++;
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("frame_seq", 8'(want.frame_seq), 8'(got.frame_seq));
      compare_field("frame_byte", want.frame_byte, got.frame_byte);
      compare_field("freed_count", 8'(want.freed_count), 8'(got.freed_count));
      compare_field("outstanding", 8'(want.outstanding), 8'(got.outstanding));
      compare_field("window_is_empty", 8'(want.window_is_empty),
                    8'(got.window_is_empty));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        cycle_count = 0;

  window_scoreboard board = new();

  go_back_n_send_window i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every result the block shows
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result(out_item);
    end
  end

  function automatic in_item_t make_item(logic [1:0] mode, logic [7:0] data,
                                         logic [SEQ_W-1:0] ack);
    in_item_t it;
    it.mode         = mode;
    it.payload_byte = data;
    it.ack_seq      = ack;
    return it;
  endfunction

  // Mostly bytes and acks inside the window, with timeouts and some noise
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it.payload_byte = 8'($urandom_range(0, 255));
    it.ack_seq      = SEQ_W'($urandom_range(0, SEQ_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.mode = MODE_DATA;
    end else if (pick < 75) begin
      it.mode = MODE_ACK;
      if (pick < 68) begin
        it.ack_seq = board.base_acked + SEQ_W'($urandom_range(0, board.in_flight));
      end
    end else if (pick < 94) begin
      it.mode = MODE_TIMEOUT;
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // Idle the sender at random, then hold the item until it is taken
  task automatic send_item(in_item_t it, int gap_pct);
    while ($urandom_range(0, 99) < gap_pct) begin
      start   <= 1'b0;
      in_item <= in_item_t'($bits(in_item_t)'($urandom));
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
  endtask

  initial begin
    int gap_pct [3];
    int sent;
    in_item_t it;
    gap_pct = '{37, 88, 0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty window: idle timeout, duplicate ack, ack beyond window, unused mode
    send_item(make_item(MODE_TIMEOUT, 8'h00, 3'd0), 0);
    send_item(make_item(MODE_ACK, 8'h00, 3'd7), 0);
    send_item(make_item(MODE_ACK, 8'hFF, 3'd0), 0);
    send_item(make_item(MODE_UNUSED, 8'hFF, 3'd7), 0);
    // Fill the window, then one byte too many
    send_item(make_item(MODE_DATA, 8'h00, 3'd7), 0);
    send_item(make_item(MODE_DATA, 8'hFF, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h5A, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'hA5, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h01, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h80, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h7F, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h33, 3'd0), 0);
    // Resend a full window, then partial, duplicate and beyond-window acks
    send_item(make_item(MODE_TIMEOUT, 8'h00, 3'd0), 0);
    send_item(make_item(MODE_ACK, 8'h00, 3'd2), 0);
    send_item(make_item(MODE_ACK, 8'h00, 3'd2), 0);
    send_item(make_item(MODE_ACK, 8'h00, 3'd1), 0);
    // Wrap the sequence number and resend across the wrap
    send_item(make_item(MODE_DATA, 8'hC3, 3'd0), 0);
    send_item(make_item(MODE_DATA, 8'h3C, 3'd0), 0);
    send_item(make_item(MODE_TIMEOUT, 8'h00, 3'd0), 0);
    // Free everything, then idle timeout and a stale ack
    send_item(make_item(MODE_ACK, 8'h00, 3'd0), 0);
    send_item(make_item(MODE_TIMEOUT, 8'h00, 3'd0), 0);
    send_item(make_item(MODE_ACK, 8'h00, 3'd7), 0);
    send_item(make_item(MODE_DATA, 8'hFF, 3'd7), 0);

    // Random traffic under three sender gap rates
    for (int p = 0; p < 3; p++) begin
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        it = random_item();
        send_item(it, gap_pct[p]);
        if (it.mode != MODE_UNUSED) sent++;
      end
    end
    start <= 1'b0;

    // Drain all expected results, then watch for strays
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes, %0d acks and %0d timeouts (%0d frames resent)",
             board.data_count, board.ack_count, board.timeout_count,
             board.resent_count);
    $display("%0d results compared field by field", board.checked_count);
    if (board.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
